@@ rtl/aes_pkg.sv @@
// ----------------------------------------------------------------------------
// AES-128 package
// S-boxes, GF(2^8) helpers, round functions and shared types.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int KEY_ROUNDS = 10;
    localparam int STORE_DEPTH = 2 * (KEY_ROUNDS + 1);
    localparam int STORE_AW = $clog2(STORE_DEPTH);
    localparam int ROUND_W = $clog2(KEY_ROUNDS + 1);

    localparam logic [0:0] ACT_ENCRYPT = 1'b0;
    localparam logic [0:0] ACT_DECRYPT = 1'b1;

    localparam logic [7:0] REG_KEY_HIGH = 8'd0;
    localparam logic [7:0] REG_KEY_LOW  = 8'd1;

    typedef enum logic [2:0] {
        t_IDLE,
        t_KEY_CLEAR,
        t_KEY_EXP,
        t_KEY_WRITE,
        t_RUN,
        t_DONE
    } t_state;

    // control from the sequencer into the round unit
    typedef struct packed {
        logic load;
        logic first;
        logic last;
        logic decrypt;
    } t_round_ctl;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[x];
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] i);
        logic [7:0] r;
        case (i)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h8d;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] x, input logic [3:0] y);
        logic [7:0] acc;
        logic [7:0] v;
        acc = 8'h00;
        v = x;
        for (int b = 0; b < 4; b++) begin
            if (y[b]) acc = acc ^ v;
            v = xt(v);
        end
        return acc;
    endfunction

    // byte k of the state sits at bits 127-8k
    function automatic logic [7:0] sb(input logic [127:0] s, input int k);
        return s[127 - 8 * k -: 8];
    endfunction

    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic mix);
        logic [127:0] o;
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                o[127 - 8 * (c * 4 + r) -: 8] = sbox(sb(s, ((c + r) & 3) * 4 + r));
        if (mix) begin
            for (int c = 0; c < 4; c++) begin
                a0 = sb(o, 4 * c); a1 = sb(o, 4 * c + 1);
                a2 = sb(o, 4 * c + 2); a3 = sb(o, 4 * c + 3);
                al = a0 ^ a1 ^ a2 ^ a3;
                o[127 - 8 * (4 * c) -: 8]     = a0 ^ al ^ xt(a0 ^ a1);
                o[127 - 8 * (4 * c + 1) -: 8] = a1 ^ al ^ xt(a1 ^ a2);
                o[127 - 8 * (4 * c + 2) -: 8] = a2 ^ al ^ xt(a2 ^ a3);
                o[127 - 8 * (4 * c + 3) -: 8] = a3 ^ al ^ xt(a3 ^ a0);
            end
        end
        return o;
    endfunction

    // inverse shift and inverse substitution
    function automatic logic [127:0] dec_sub(input logic [127:0] s);
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                o[127 - 8 * (((c + r) & 3) * 4 + r) -: 8] = inv_sbox(sb(s, c * 4 + r));
        return o;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] o;
        logic [3:0] coef [4];
        logic [7:0] v;
        coef = '{4'hE, 4'hB, 4'hD, 4'h9};
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                v = 8'h00;
                for (int k = 0; k < 4; k++)
                    v = v ^ gmul(sb(s, 4 * c + k), coef[(k - r + 4) & 3]);
                o[127 - 8 * (4 * c + r) -: 8] = v;
            end
        return o;
    endfunction

endpackage

@@ rtl/aes_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module aes_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 22
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/aes_key_exp.sv @@
// ----------------------------------------------------------------------------
// AES-128 key expansion step
// Holds the running four-word key and advances it one round per request.
// ----------------------------------------------------------------------------
module aes_key_exp (
    input  logic         i_clk,
    input  logic         i_load,
    input  logic [127:0] i_key,
    input  logic         i_step,
    input  logic [3:0]   i_round,
    output logic [127:0] o_key
);
    import aes_pkg::*;

    logic [127:0] r_key;
    logic [127:0] n_key;
    logic [31:0]  w0, w1, w2, w3, t;

    always_comb begin
        w0 = r_key[127:96]; w1 = r_key[95:64]; w2 = r_key[63:32]; w3 = r_key[31:0];
        t = {sbox(w3[23:16]), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        t[31:24] = t[31:24] ^ rcon(i_round);
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        n_key = {w0, w1, w2, w3};
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_key <= i_key;
        else if (i_step) r_key <= n_key;
    end

    assign o_key = r_key;
endmodule

@@ rtl/aes_round.sv @@
// ----------------------------------------------------------------------------
// AES round unit
// Shared encrypt / decrypt round, one round per cycle while i_step is high, on the state register.
// ----------------------------------------------------------------------------
module aes_round (
    input  logic                i_clk,
    input  aes_pkg::t_round_ctl i_ctl,
    input  logic                i_step,
    input  logic [127:0]        i_block,
    input  logic [127:0]        i_rkey,
    output logic [127:0]        o_state
);
    import aes_pkg::*;

    logic [127:0] r_state;
    logic [127:0] n_state;
    logic [127:0] e_out;
    logic [127:0] d_out;

    always_comb begin
        e_out = enc_round(r_state, !i_ctl.last) ^ i_rkey;
        d_out = dec_sub(r_state) ^ i_rkey;
        if (!i_ctl.last) d_out = inv_mix(d_out);
        // the block was captured at load; the first step only adds the key
        if (i_ctl.first) n_state = r_state ^ i_rkey;
        else if (i_ctl.decrypt) n_state = d_out;
        else n_state = e_out;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) r_state <= i_block;
        else if (i_step) r_state <= n_state;
    end

    assign o_state = r_state;
endmodule

@@ rtl/aes128_block_cipher_top.sv @@
// ----------------------------------------------------------------------------
// AES-128 block cipher
// Iterative AES-128 encrypt / decrypt with a cached round key schedule.
// ----------------------------------------------------------------------------
// A key register write re-runs the key schedule: a load state, then 22
// cache writes (one 64-bit half per cycle) interleaved with 10 expansion
// steps, with the input side held off meanwhile. A block then runs on the
// shared round unit; the single 64-bit cache read port returns one half of
// a round key per cycle, so a round is applied once both halves of its key
// are in. The done state then raises the output valid. The result waits in
// the round unit's state register; the next block is taken once it is out.
// Blocks must not be sent before the first key write.
module aes128_block_cipher_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [0:0]   i_action,
    input  logic [63:0]  i_block_high,
    input  logic [63:0]  i_block_low,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [63:0]  o_result_high,
    output logic [63:0]  o_result_low,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data
);
    import aes_pkg::*;

    t_state       r_state, n_state;
    logic [3:0]   r_cnt, n_cnt;
    logic         r_half, n_half;
    logic         r_dec, n_dec;
    logic [63:0]  r_key_high, r_key_low;
    logic         r_out_valid, n_out_valid;
    logic [63:0]  r_rk_hi;
    logic         r_rd_hi;
    logic [127:0] rkey;

    logic         cfg_fire, in_fire;
    logic         ke_load, ke_step;
    logic [127:0] ke_key;
    logic         ram_we;
    logic [STORE_AW-1:0] ram_waddr, ram_raddr;
    logic [63:0]  ram_wdata, ram_rdata;
    t_round_ctl   rctl;
    logic         rstep;
    logic [127:0] st;
    logic [3:0]   rd_round;

    assign cfg_fire = i_cfg_valid && o_cfg_ready;
    assign in_fire  = i_valid && o_ready;
    assign o_cfg_ready = (r_state == t_IDLE) && !r_out_valid;
    assign o_ready  = (r_state == t_IDLE) && !r_out_valid && !i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_IDLE;
            r_cnt <= '0;
            r_half <= 1'b0;
            r_dec <= 1'b0;
            r_out_valid <= 1'b0;
            r_key_high <= '0;
            r_key_low <= '0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_half <= n_half;
            r_dec <= n_dec;
            r_out_valid <= n_out_valid;
            if (cfg_fire && i_cfg_index == REG_KEY_HIGH) r_key_high <= i_cfg_data;
            if (cfg_fire && i_cfg_index == REG_KEY_LOW)  r_key_low  <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_hi) r_rk_hi <= ram_rdata;
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_half = r_half;
        n_dec = r_dec;
        n_out_valid = r_out_valid;
        ke_load = 1'b0;
        ke_step = 1'b0;
        ram_we = 1'b0;
        ram_wdata = r_half ? ke_key[63:0] : ke_key[127:64];
        ram_waddr = {r_cnt[STORE_AW-2:0], r_half};
        rd_round = '0;
        if (r_out_valid && i_ready) n_out_valid = 1'b0;
        case (r_state)
            t_IDLE: begin
                if (cfg_fire && (i_cfg_index == REG_KEY_HIGH || i_cfg_index == REG_KEY_LOW))
                begin
                    n_state = t_KEY_CLEAR;
                end else if (in_fire) begin
                    n_dec = i_action == ACT_DECRYPT;
                    n_cnt = '0;
                    n_half = 1'b0;
                    n_state = t_RUN;
                end
            end
            t_KEY_CLEAR: begin
                ke_load = 1'b1;
                n_cnt = '0;
                n_half = 1'b0;
                n_state = t_KEY_WRITE;
            end
            t_KEY_WRITE: begin
                ram_we = 1'b1;
                n_half = !r_half;
                if (r_half) begin
                    if (r_cnt == 4'(KEY_ROUNDS)) n_state = t_IDLE;
                    else n_state = t_KEY_EXP;
                end
            end
            t_KEY_EXP: begin
                ke_step = 1'b1;
                n_cnt = r_cnt + 4'd1;
                n_state = t_KEY_WRITE;
            end
            t_RUN: begin
                // r_cnt counts rounds, r_half the read phase: 2 reads per round, plus pipeline slack
                if (r_cnt <= 4'(KEY_ROUNDS)) rd_round = r_dec ? 4'(KEY_ROUNDS) - r_cnt : r_cnt;
                n_half = !r_half;
                if (r_half) begin
                    n_cnt = r_cnt + 4'd1;
                end
                n_state = t_RUN;
                if (r_cnt == 4'(KEY_ROUNDS + 1) && r_half) n_state = t_DONE;
            end
            t_DONE: begin
                n_out_valid = 1'b1;
                n_state = t_IDLE;
            end
            default: n_state = t_IDLE;
        endcase
    end

    // read address: high half on even phase, low half on odd phase
    assign ram_raddr = {rd_round[STORE_AW-2:0], r_half};

    logic r_rd_lo;
    logic [3:0] r_rd_cnt;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_hi <= 1'b0;
            r_rd_lo <= 1'b0;
            r_rd_cnt <= '0;
        end else begin
            r_rd_hi <= (r_state == t_RUN) && !r_half && (r_cnt <= 4'(KEY_ROUNDS));
            r_rd_lo <= (r_state == t_RUN) && r_half && (r_cnt <= 4'(KEY_ROUNDS));
            if (r_state == t_RUN && r_half) r_rd_cnt <= r_cnt;
        end
    end

    // apply a round when the low half arrives; high half was captured before
    assign rkey = {r_rk_hi, ram_rdata};
    always_comb begin
        rctl.load = in_fire;
        rctl.first = r_rd_cnt == 4'd0;
        rctl.last = r_rd_cnt == 4'(KEY_ROUNDS);
        rctl.decrypt = r_dec;
        rstep = r_rd_lo;
    end

    aes_key_exp u_key_exp (
        .i_clk   (i_clk),
        .i_load  (ke_load),
        .i_key   ({r_key_high, r_key_low}),
        .i_step  (ke_step),
        .i_round (r_cnt + 4'd1),
        .o_key   (ke_key)
    );

    aes_ram #(.WIDTH(64), .DEPTH(STORE_DEPTH)) u_rk_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    aes_round u_round (
        .i_clk   (i_clk),
        .i_ctl   (rctl),
        .i_step  (rstep),
        .i_block ({i_block_high, i_block_low}),
        .i_rkey  (rkey),
        .o_state (st)
    );

    assign o_valid = r_out_valid;
    assign o_result_high = st[127:64];
    assign o_result_low  = st[63:0];

    // never accept a block while a result is still pending
    assert property (@(posedge i_clk) disable iff (!i_rst_n) in_fire |-> !r_out_valid)
        else $error("block taken while result pending");
    // a result appears only after the sequencer finishes
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == t_DONE)
        else $error("result without finished run");
    // cache is never written during a run
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == t_RUN |-> !ram_we)
        else $error("key cache written during a run");
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-128 block cipher testbench
// Drives key writes and blocks over valid/ready with random gaps and stalls,
// predicts each result with an in-bench AES-128 model and checks every field.
// ----------------------------------------------------------------------------
module tb_top;
    import aes_pkg::*;

    localparam logic [7:0] REG_SPARE_LO = 8'd2;
    localparam logic [7:0] REG_SPARE_HI = 8'hFF;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] { JOB_BLOCK, JOB_KEY, JOB_DRAIN } t_job_kind;

    typedef struct {
        t_job_kind   kind;
        logic [7:0]  idx;
        logic [63:0] data;
        logic [0:0]  act;
        logic [63:0] hi;
        logic [63:0] lo;
    } t_job;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
    } t_block;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_valid = 1'b0;
    logic         o_ready;
    logic [0:0]   i_action = ACT_ENCRYPT;
    logic [63:0]  i_block_high = '0;
    logic [63:0]  i_block_low = '0;
    logic         o_valid;
    logic         i_ready = 1'b0;
    logic [63:0]  o_result_high;
    logic [63:0]  o_result_low;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [7:0]   i_cfg_index = '0;
    logic [63:0]  i_cfg_data = '0;

    aes128_block_cipher_top u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [7:0] fwd_box [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
    logic [7:0] rev_box [256];

    logic [63:0]  key_hi = '0;
    logic [63:0]  key_lo = '0;
    logic [127:0] round_keys [11];

    t_job   block_jobs [$];
    t_block cipher_results_due [$];
    int     errors = 0;
    int     results_checked = 0;
    int     key_writes = 0;
    int     blocks_queued = 0;
    bit     quiet = 1'b0;

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [3:0] c);
        logic [7:0] acc;
        acc = 8'h00;
        for (int b = 0; b < 4; b++) begin
            if (c[b]) acc ^= x;
            x = xtime(x);
        end
        return acc;
    endfunction

    function automatic void key_schedule();
        logic [31:0] w [44];
        logic [31:0] t;
        logic [7:0]  rc;
        w[0] = key_hi[63:32]; w[1] = key_hi[31:0];
        w[2] = key_lo[63:32]; w[3] = key_lo[31:0];
        rc = 8'h01;
        for (int i = 4; i < 44; i++) begin
            t = w[i - 1];
            if (i % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {fwd_box[t[31:24]], fwd_box[t[23:16]], fwd_box[t[15:8]], fwd_box[t[7:0]]};
                t[31:24] ^= rc;
                rc = xtime(rc);
            end
            w[i] = w[i - 4] ^ t;
        end
        for (int r = 0; r < 11; r++)
            round_keys[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
    endfunction

    function automatic void key_write(input logic [7:0] idx, input logic [63:0] data);
        if (idx == REG_KEY_HIGH) key_hi = data;
        else if (idx == REG_KEY_LOW) key_lo = data;
        else return;
        key_schedule();
    endfunction

    // state byte k = column * 4 + row, byte 0 in the top bits
    function automatic logic [127:0] aes_transform(input logic [0:0] act, input logic [127:0] blk);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al, v;
        logic [3:0] coef [4];
        logic [127:0] o;
        coef = '{4'hE, 4'hB, 4'hD, 4'h9};
        for (int b = 0; b < 16; b++) s[b] = blk[127 - 8 * b -: 8];
        if (act == ACT_ENCRYPT) begin
            for (int b = 0; b < 16; b++) s[b] ^= round_keys[0][127 - 8 * b -: 8];
            for (int r = 1; r <= 10; r++) begin
                for (int c = 0; c < 4; c++)
                    for (int w = 0; w < 4; w++)
                        t[c * 4 + w] = fwd_box[s[((c + w) & 3) * 4 + w]];
                if (r < 10) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
                        al = a0 ^ a1 ^ a2 ^ a3;
                        t[4 * c]     = a0 ^ al ^ xtime(a0 ^ a1);
                        t[4 * c + 1] = a1 ^ al ^ xtime(a1 ^ a2);
                        t[4 * c + 2] = a2 ^ al ^ xtime(a2 ^ a3);
                        t[4 * c + 3] = a3 ^ al ^ xtime(a3 ^ a0);
                    end
                end
                for (int b = 0; b < 16; b++) s[b] = t[b] ^ round_keys[r][127 - 8 * b -: 8];
            end
        end else begin
            for (int b = 0; b < 16; b++) s[b] ^= round_keys[10][127 - 8 * b -: 8];
            for (int r = 9; r >= 0; r--) begin
                for (int c = 0; c < 4; c++)
                    for (int w = 0; w < 4; w++)
                        t[((c + w) & 3) * 4 + w] = rev_box[s[c * 4 + w]];
                for (int b = 0; b < 16; b++) t[b] ^= round_keys[r][127 - 8 * b -: 8];
                for (int c = 0; c < 4; c++)
                    for (int w = 0; w < 4; w++) begin
                        v = 8'h00;
                        for (int k = 0; k < 4; k++)
                            v ^= gf_mul(t[4 * c + k], coef[(k - w + 4) & 3]);
                        s[4 * c + w] = (r > 0) ? v : t[4 * c + w];
                    end
            end
        end
        for (int b = 0; b < 16; b++) o[127 - 8 * b -: 8] = s[b];
        return o;
    endfunction

    // mostly short gaps, a few long ones, none at all while quiet
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] rand_half();
        case ($urandom_range(0, 15))
            0: return 64'h0;
            1: return ALL_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic add_block(input logic [0:0] act, input logic [63:0] hi, input logic [63:0] lo);
        t_job j;
        j.kind = JOB_BLOCK; j.act = act; j.hi = hi; j.lo = lo; j.idx = '0; j.data = '0;
        block_jobs.push_back(j);
        blocks_queued++;
    endtask

    task automatic add_key(input logic [7:0] idx, input logic [63:0] data);
        t_job j;
        j.kind = JOB_KEY; j.idx = idx; j.data = data; j.act = ACT_ENCRYPT; j.hi = '0; j.lo = '0;
        block_jobs.push_back(j);
    endtask

    task automatic add_drain();
        t_job j;
        j.kind = JOB_DRAIN; j.idx = '0; j.data = '0; j.act = ACT_ENCRYPT; j.hi = '0; j.lo = '0;
        block_jobs.push_back(j);
    endtask

    // driver: blocks and key writes from the job queue
    int     gap_left = 0;
    logic   held_blk, held_cfg, raise_blk, raise_cfg;
    t_job   job;
    t_block due;
    logic [127:0] pred;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            held_blk = i_valid && !o_ready;
            held_cfg = i_cfg_valid && !o_cfg_ready;
            if (i_valid && o_ready) begin
                pred = aes_transform(i_action, {i_block_high, i_block_low});
                due.hi = pred[127:64];
                due.lo = pred[63:0];
                cipher_results_due.push_back(due);
                if ($urandom_range(0, 63) == 0) quiet = !quiet;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                key_write(i_cfg_index, i_cfg_data);
                key_writes++;
            end
            raise_blk = held_blk;
            raise_cfg = held_cfg;
            if (!held_blk && !held_cfg) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (block_jobs.size() > 0) begin
                    job = block_jobs[0];
                    if (job.kind == JOB_BLOCK) begin
                        void'(block_jobs.pop_front());
                        i_action <= job.act;
                        i_block_high <= job.hi;
                        i_block_low <= job.lo;
                        raise_blk = 1'b1;
                        gap_left = pick_gap();
                    end else if (cipher_results_due.size() == 0) begin
                        // key writes and drains wait for the block to go idle
                        void'(block_jobs.pop_front());
                        if (job.kind == JOB_KEY) begin
                            i_cfg_index <= job.idx;
                            i_cfg_data <= job.data;
                            raise_cfg = 1'b1;
                        end
                    end
                end
            end
            i_valid <= raise_blk;
            i_cfg_valid <= raise_cfg;
        end
    end

    // monitor: random back-pressure and result check
    int stall_left = 0;
    t_block want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (cipher_results_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h_%h",
                             $time, o_result_high, o_result_low);
                    errors++;
                end else begin
                    want = cipher_results_due.pop_front();
                    results_checked++;
                    if (o_result_high !== want.hi) begin
                        $display("%0t: result_high mismatch, expected %h, got %h",
                                 $time, want.hi, o_result_high);
                        errors++;
                    end
                    if (o_result_low !== want.lo) begin
                        $display("%0t: result_low mismatch, expected %h, got %h",
                                 $time, want.lo, o_result_low);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int n;
        for (int i = 0; i < 256; i++) rev_box[fwd_box[i]] = i[7:0];

        // directed: half-written key, standard vector, extremes, ignored indexes
        add_key(REG_KEY_HIGH, 64'h0001_0203_0405_0607);
        add_block(ACT_ENCRYPT, 64'h0, 64'h0);
        add_key(REG_KEY_LOW, 64'h0809_0A0B_0C0D_0E0F);
        add_block(ACT_ENCRYPT, 64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF);
        add_block(ACT_DECRYPT, 64'h69C4_E0D8_6A7B_0430, 64'hD8CD_B780_70B4_C55A);
        add_block(ACT_ENCRYPT, 64'h0, 64'h0);
        add_block(ACT_ENCRYPT, ALL_ONES, ALL_ONES);
        add_block(ACT_DECRYPT, 64'h0, 64'h0);
        add_block(ACT_DECRYPT, ALL_ONES, ALL_ONES);
        add_block(ACT_ENCRYPT, ALL_ONES, 64'h0);
        add_block(ACT_DECRYPT, 64'h0, ALL_ONES);
        add_key(REG_SPARE_LO, ALL_ONES);
        add_key(REG_SPARE_HI, {$urandom, $urandom});
        add_block(ACT_ENCRYPT, 64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF);
        add_block(ACT_DECRYPT, 64'h69C4_E0D8_6A7B_0430, 64'hD8CD_B780_70B4_C55A);
        add_key(REG_KEY_LOW, ALL_ONES);
        add_block(ACT_ENCRYPT, {$urandom, $urandom}, {$urandom, $urandom});
        add_block(ACT_DECRYPT, {$urandom, $urandom}, {$urandom, $urandom});
        add_key(REG_KEY_HIGH, ALL_ONES);
        add_block(ACT_ENCRYPT, 64'h0, 64'h0);
        add_block(ACT_DECRYPT, ALL_ONES, ALL_ONES);
        add_key(REG_KEY_HIGH, 64'h0);
        add_key(REG_KEY_LOW, 64'h0);
        add_block(ACT_ENCRYPT, 64'h0, 64'h0);
        add_block(ACT_DECRYPT, 64'h0, 64'h0);
        add_drain();

        // random phases, each under a fresh key setting
        while (blocks_queued < 1330) begin
            case ($urandom_range(0, 3))
                0: add_key(REG_KEY_HIGH, rand_half());
                1: add_key(REG_KEY_LOW, rand_half());
                default: begin
                    add_key(REG_KEY_HIGH, rand_half());
                    add_key(REG_KEY_LOW, rand_half());
                end
            endcase
            n = $urandom_range(60, 200);
            for (int i = 0; i < n; i++) begin
                add_block(1'($urandom_range(0, 1)), rand_half(), rand_half());
                if ($urandom_range(0, 39) == 0) add_drain();
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (block_jobs.size() > 0 || i_valid || i_cfg_valid || cipher_results_due.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Checked %0d encrypt/decrypt results across %0d key register transfers.",
                 results_checked, key_writes);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
